/* hdl/transparent_run_length_tile_encoder_macros.svh */
// Assertion macros for the transparent run-length tile encoder.
// Included by the top level; depends on nothing else.
`ifndef TRANSPARENT_RUN_LENGTH_TILE_ENCODER_MACROS_SVH
`define TRANSPARENT_RUN_LENGTH_TILE_ENCODER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define TRLTE_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define TRLTE_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hdl/trlte_pkg.sv */
// Shared types and constants for the transparent run-length tile encoder.
// No dependencies.
package trlte_pkg;

    localparam int ROW_WIDTH_DEF = 32;
    localparam int ROW_IDX_W     = 5;
    localparam int RECT_ROWS     = 32;
    localparam int DIAMOND_ROWS  = 15;
    localparam int DIAMOND_MID   = 7;
    localparam int BYTE_W        = 8;
    localparam int SEL_W         = 2;

    // Register byte addresses
    localparam logic [1:0] REG_DIAMOND_MODE = 2'd0;

    // Output byte source codes
    localparam logic [SEL_W-1:0] SEL_TCNT = 2'd0;
    localparam logic [SEL_W-1:0] SEL_SCNT = 2'd1;
    localparam logic [SEL_W-1:0] SEL_PIX  = 2'd2;
    localparam logic [SEL_W-1:0] SEL_ZERO = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic             accept;
        logic             load;
        logic [SEL_W-1:0] sel;
        logic             burst_last;
        logic             tile_end_en;
        logic             idx_inc;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic run_now;
        logic eor_now;
        logic eor_reg;
        logic idx_last;
        logic slot_free;
    } dp_status_t;

endpackage

/* hdl/trlte_pix_if.sv */
// Input channel carrying one palette pixel per transaction.
// Depends on trlte_pkg.
interface trlte_pix_if
    import trlte_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

/* hdl/trlte_byte_if.sv */
// Output channel carrying one encoded byte per transaction.
// Depends on trlte_pkg.
interface trlte_byte_if
    import trlte_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              burst_last;
    logic              tile_end;

    modport source (output valid, output out_byte, output burst_last, output tile_end,
                    input ready);
    modport sink   (input valid, input out_byte, input burst_last, input tile_end,
                    output ready);
endinterface

/* hdl/trlte_ctrl.sv */
// Sequencing state machine of the tile encoder: accepts pixels and steps
// through the bytes of each run and row end. Depends on trlte_pkg.
module trlte_ctrl
    import trlte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TCNT = 3'd1;
    localparam logic [2:0] ST_SCNT = 3'd2;
    localparam logic [2:0] ST_PIX  = 3'd3;
    localparam logic [2:0] ST_EOR0 = 3'd4;
    localparam logic [2:0] ST_EOR1 = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SEL_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.run_now)
                        state_next = ST_TCNT;
                    else if (status.eor_now)
                        state_next = ST_EOR0;
                end
            end
            ST_TCNT:
            begin
                cmd.sel = SEL_TCNT;
                if (status.slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCNT;
                end
            end
            ST_SCNT:
            begin
                cmd.sel = SEL_SCNT;
                if (status.slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PIX;
                end
            end
            ST_PIX:
            begin
                cmd.sel        = SEL_PIX;
                cmd.burst_last = status.idx_last && !status.eor_reg;
                if (status.slot_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_inc = !status.idx_last;
                    if (status.idx_last)
                        state_next = status.eor_reg ? ST_EOR0 : ST_IDLE;
                end
            end
            ST_EOR0:
            begin
                if (status.slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EOR1;
                end
            end
            ST_EOR1:
            begin
                cmd.burst_last  = 1'b1;
                cmd.tile_end_en = 1'b1;
                if (status.slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* hdl/trlte_dpath.sv */
// Datapath of the tile encoder: position and run counters, solid pixel
// row buffer, mode register and output register. Depends on trlte_pkg.
module trlte_dpath
    import trlte_pkg::*;
#(
    parameter int ROW_WIDTH = ROW_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    output logic              mode,
    input  logic [BYTE_W-1:0] pixel,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [BYTE_W-1:0] out_byte,
    output logic              burst_last,
    output logic              tile_end
);

    localparam int COL_W = $clog2(ROW_WIDTH);
    localparam int CNT_W = $clog2(ROW_WIDTH + 1);
    localparam int CMP_W = ((COL_W > ROW_IDX_W + 1) ? COL_W : ROW_IDX_W + 1) + 1;

    logic                 mode_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_IDX_W-1:0] row_reg;
    logic [CNT_W-1:0]     tc_reg;
    logic [CNT_W-1:0]     sc_reg;
    logic [CNT_W-1:0]     run_t_reg;
    logic [CNT_W-1:0]     run_s_reg;
    logic                 eor_reg;
    logic                 last_row_reg;
    logic [COL_W-1:0]     idx_reg;
    logic [COL_W-1:0]     idx_next;
    logic [BYTE_W-1:0]    rd_reg;
    logic [BYTE_W-1:0]    buf_mem [ROW_WIDTH];

    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic                 burst_last_reg;
    logic                 tile_end_reg;

    logic [ROW_IDX_W-1:0] row_dist;
    logic [CMP_W-1:0]     lo;
    logic [CMP_W-1:0]     col_ext;
    logic                 in_diamond;
    logic [BYTE_W-1:0]    pix_eff;
    logic                 solid;
    logic [CNT_W-1:0]     sc_new;
    logic                 eor_now;
    logic                 run_now;
    logic                 last_row;
    logic [ROW_IDX_W:0]   row_inc;
    logic                 slot_free;
    logic [BYTE_W-1:0]    byte_mux;

    // Diamond mask: inside when 2*|mid-y| <= x < width-2*|mid-y|
    always_comb
    begin
        if (row_reg >= ROW_IDX_W'(DIAMOND_MID))
            row_dist = row_reg - ROW_IDX_W'(DIAMOND_MID);
        else
            row_dist = ROW_IDX_W'(DIAMOND_MID) - row_reg;
        lo         = CMP_W'({row_dist, 1'b0});
        col_ext    = CMP_W'(col_reg);
        in_diamond = (col_ext >= lo) && ((col_ext + lo) < CMP_W'(ROW_WIDTH));
    end

    // Classify the incoming pixel and plan its output
    always_comb
    begin
        pix_eff  = (mode_reg && !in_diamond) ? '0 : pixel;
        solid    = (pix_eff != '0);
        sc_new   = solid ? sc_reg + CNT_W'(1) : sc_reg;
        eor_now  = (col_reg == COL_W'(ROW_WIDTH - 1));
        run_now  = (!solid && sc_reg != '0) || (eor_now && sc_new != '0);
        row_inc  = {1'b0, row_reg} + (ROW_IDX_W + 1)'(1);
        last_row = mode_reg ? (row_inc >= (ROW_IDX_W + 1)'(DIAMOND_ROWS))
                            : (row_inc >= (ROW_IDX_W + 1)'(RECT_ROWS));
    end

    // Hold mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    // Advance position and run counters on each accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            tc_reg  <= '0;
            sc_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            if (eor_now)
            begin
                col_reg <= '0;
                tc_reg  <= '0;
                sc_reg  <= '0;
                row_reg <= last_row ? '0 : row_inc[ROW_IDX_W-1:0];
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
                if (!solid)
                begin
                    tc_reg <= (sc_reg != '0) ? CNT_W'(1) : tc_reg + CNT_W'(1);
                    sc_reg <= '0;
                end
                else
                begin
                    sc_reg <= sc_new;
                end
            end
        end
    end

    // Latch the run and row-end plan of the accepted pixel
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            run_t_reg    <= tc_reg;
            run_s_reg    <= sc_new;
            eor_reg      <= eor_now;
            last_row_reg <= last_row;
        end
    end

    // Step through the buffered pixels of a run
    always_comb
    begin
        if (cmd.accept)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + COL_W'(1);
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    // Row buffer: write solid pixels, read ahead at the next index
    always_ff @(posedge clk)
    begin
        if (cmd.accept && solid)
            buf_mem[sc_reg[COL_W-1:0]] <= pix_eff;
        rd_reg <= buf_mem[idx_next];
    end

    // Select the byte to emit
    always_comb
    begin
        case (cmd.sel)
            SEL_TCNT: byte_mux = BYTE_W'(run_t_reg);
            SEL_SCNT: byte_mux = BYTE_W'(run_s_reg);
            SEL_PIX:  byte_mux = rd_reg;
            default:  byte_mux = '0;
        endcase
    end

    assign slot_free = !out_valid_reg || out_ready;

    // Hold output transaction until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_byte_reg   <= byte_mux;
            burst_last_reg <= cmd.burst_last;
            tile_end_reg   <= cmd.tile_end_en && last_row_reg;
        end
    end

    assign status.run_now   = run_now;
    assign status.eor_now   = eor_now;
    assign status.eor_reg   = eor_reg;
    assign status.idx_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == run_s_reg);
    assign status.slot_free = slot_free;

    assign mode       = mode_reg;
    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign burst_last = burst_last_reg;
    assign tile_end   = tile_end_reg;

endmodule

/* hdl/transparent_run_length_tile_encoder.sv */
// Transparent run-length tile encoder.
// Palette pixels arrive on pix_in, one per transaction, row by row, ROW_WIDTH per row.
// Pixel 0 is transparent. Each solid run leaves on byte_out as the transparent count,
// the solid count and the solid pixels; every row ends with two zero bytes.
// A row's transparent tail produces nothing. burst_last marks the last byte caused
// by a pixel; tile_end marks the final end-of-row zero of the tile.
// Register diamond_mode (APB, address 0): 0 rectangle tile of 32 rows,
// 1 diamond tile of 15 rows with pixels outside the diamond forced transparent.
// Timing: a pixel that closes nothing is taken without holding pix_in. A pixel that
// closes a run of s solid pixels holds pix_in while the sequencer sends the two counts
// and the s pixels (and at a row end the two zeros), one byte per cycle unless
// byte_out stalls; a row end alone sends the two zeros. The first byte reaches
// byte_out through the state register and then the output register. The sequencer
// reads the row buffer one entry per cycle; byte_out stalls hold it. pix_in stays
// ready while the last byte of a burst waits in the output register.
// Reset clears position, counters, mode and output valid; the buffer needs no clearing.
// Depends on trlte_pkg, trlte_pix_if, trlte_byte_if, trlte_ctrl, trlte_dpath.
`include "transparent_run_length_tile_encoder_macros.svh"

module transparent_run_length_tile_encoder
    import trlte_pkg::*;
#(
    parameter int ROW_WIDTH = ROW_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    trlte_pix_if.sink    pix_in,
    trlte_byte_if.source byte_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       mode;
    logic       cfg_we;
    logic       pix_accept;
    logic       tile_end_seen;
    logic       quiet_accept;
    logic       run_accept;

    // Configuration write on the access phase
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == REG_DIAMOND_MODE);
    assign prdata = {31'd0, mode};

    trlte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (pix_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    trlte_dpath #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (pwdata[0]),
        .mode       (mode),
        .pixel      (pix_in.pixel),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (byte_out.ready),
        .out_valid  (byte_out.valid),
        .out_byte   (byte_out.out_byte),
        .burst_last (byte_out.burst_last),
        .tile_end   (byte_out.tile_end)
    );

    assign pix_accept    = pix_in.valid && pix_in.ready;
    assign tile_end_seen = byte_out.valid && byte_out.tile_end;
    assign quiet_accept  = pix_accept && !status.run_now && !status.eor_now;
    assign run_accept    = pix_accept && status.run_now;

    // Tile end is always the last byte of its burst
    `TRLTE_ASSERT_NOW(a_tile_last, clk, rst_n, tile_end_seen, byte_out.burst_last, "tile_end alone")
    // A pixel that closes nothing leaves the input open
    `TRLTE_ASSERT_NEXT(a_quiet_pixel, clk, rst_n, quiet_accept, pix_in.ready, "input closed")
    // A pixel that closes a run blocks the input while the run is sent
    `TRLTE_ASSERT_NEXT(a_run_blocks, clk, rst_n, run_accept, !pix_in.ready, "input open in burst")
    // Loads only go out when the output register has room
    `TRLTE_ASSERT_NOW(a_load_room, clk, rst_n, cmd.load, status.slot_free, "output overwritten")

endmodule

/* sim/tb.sv */
// Self-checking testbench for the transparent run-length tile encoder.
// Drives pixels and the mode register, predicts the encoded byte stream.
// Depends on trlte_pkg, trlte_pix_if, trlte_byte_if and the encoder top level.
`timescale 1ns / 100ps

module tb
    import trlte_pkg::*;
;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int          DRAIN_WAIT  = 40;
    localparam int          IDLE_WAIT   = 8;

    localparam bit         MODE_RECT        = 1'b0;
    localparam bit         MODE_DIAMOND     = 1'b1;
    localparam logic [7:0] CLEAR_PIXEL      = 8'd0;

    // Hand-written opening row: extremes, alternating bits, runs cut by
    // transparent pixels, then a transparent tail filled in afterwards.
    localparam logic [7:0] OPENING_ROW [14] = '{
        8'h00, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h55, 8'hAA,
        8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h01
    };

    typedef enum int {ROW_SOLID, ROW_CLEAR, ROW_SPARSE, ROW_NOISE, ROW_RUNS} row_style_t;
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_COMB} sink_style_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       tile_end;
    } enc_byte_t;

    // Predicts the encoded stream and checks it against the output channel.
    class tile_scoreboard;
        bit         diamond_on;
        int         pos_x;
        int         pos_y;
        int         gap_len;
        int         run_len;
        logic [7:0] run_pixels [ROW_WIDTH_DEF];
        enc_byte_t  expected_bytes [$];
        int         errors;

        task report_mismatch(string msg);
            $display("tb: mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function void queue_byte(logic [7:0] value, logic tile_end);
            enc_byte_t b;
            b.value    = value;
            b.last     = 1'b0;
            b.tile_end = tile_end;
            expected_bytes.push_back(b);
        endfunction

        // Flush the pending run: gap count, run count, then the run's pixels.
        function void queue_run();
            queue_byte(8'(gap_len), 1'b0);
            queue_byte(8'(run_len), 1'b0);
            for (int i = 0; i < run_len; i++)
                queue_byte(run_pixels[i], 1'b0);
            run_len = 0;
        endfunction

        function bit in_diamond();
            int row_off;
            int margin;
            row_off = pos_y - DIAMOND_MID;
            if (row_off < 0)
                row_off = -row_off;
            margin = 2 * row_off;
            return pos_x >= margin && pos_x < ROW_WIDTH_DEF - margin;
        endfunction

        function void note_pixel(logic [7:0] pixel);
            logic [7:0] px;
            int         queued_before;
            int         tile_rows;
            bit         last_row;
            enc_byte_t  tail;
            queued_before = expected_bytes.size();
            tile_rows     = diamond_on ? DIAMOND_ROWS : RECT_ROWS;
            px            = pixel;
            // Force pixels outside the diamond to transparent
            if (diamond_on && !in_diamond())
                px = CLEAR_PIXEL;
            if (px == CLEAR_PIXEL)
            begin
                if (run_len > 0)
                begin
                    queue_run();
                    gap_len = 1;
                end
                else
                begin
                    gap_len++;
                end
            end
            else
            begin
                run_pixels[run_len] = px;
                run_len++;
            end
            // Close the row: pending run, then the two end-of-row zeros
            if (pos_x == ROW_WIDTH_DEF - 1)
            begin
                last_row = (pos_y + 1 >= tile_rows);
                if (run_len > 0)
                    queue_run();
                queue_byte(8'd0, 1'b0);
                queue_byte(8'd0, last_row);
                pos_x   = 0;
                gap_len = 0;
                run_len = 0;
                pos_y   = last_row ? 0 : pos_y + 1;
            end
            else
            begin
                pos_x++;
            end
            // Mark the last byte of this pixel's burst
            if (expected_bytes.size() > queued_before)
            begin
                tail      = expected_bytes.pop_back();
                tail.last = 1'b1;
                expected_bytes.push_back(tail);
            end
        endfunction

        task check_byte(logic [7:0] value, logic last, logic tile_end);
            enc_byte_t exp_b;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h", value));
            end
            else
            begin
                exp_b = expected_bytes.pop_front();
                if (value !== exp_b.value)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              value, exp_b.value));
                if (last !== exp_b.last)
                    report_mismatch($sformatf("burst_last %b, expected %b on byte %02h",
                                              last, exp_b.last, exp_b.value));
                if (tile_end !== exp_b.tile_end)
                    report_mismatch($sformatf("tile_end %b, expected %b on byte %02h",
                                              tile_end, exp_b.tile_end, exp_b.value));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    trlte_pix_if  pix_if ();
    trlte_byte_if byte_if ();

    tile_scoreboard sb = new();

    int          burst_left  = 0;
    int unsigned cycle_count = 0;
    sink_style_t sink_style  = SINK_OPEN;
    int          sink_left   = 0;
    int          sink_period = 2;
    int          sink_hold   = 1;
    int          sink_phase  = 0;

    transparent_run_length_tile_encoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_if),
        .byte_out (byte_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Check each output transaction and pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && byte_if.valid && byte_if.ready)
            sb.check_byte(byte_if.out_byte, byte_if.burst_last, byte_if.tile_end);
        if (sink_left == 0)
        begin
            sink_style  = sink_style_t'($urandom_range(SINK_OPEN, SINK_COMB));
            sink_left   = $urandom_range(10, 60);
            sink_period = $urandom_range(2, 10);
            sink_hold   = $urandom_range(1, sink_period - 1);
        end
        sink_left--;
        sink_phase++;
        case (sink_style)
            SINK_OPEN: byte_if.ready <= 1'b1;
            SINK_COIN: byte_if.ready <= 1'($urandom_range(0, 1));
            default:   byte_if.ready <= (sink_phase % sink_period) >= sink_hold;
        endcase
    end

    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [1:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drain the block, confirm the current mode, then write the new one
    task automatic set_mode(input bit mode);
        logic [31:0] mode_rd;
        pix_if.valid <= 1'b0;
        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        apb_read(REG_DIAMOND_MODE, mode_rd);
        if (mode_rd !== {31'd0, sb.diamond_on})
            sb.report_mismatch($sformatf("diamond_mode reads %08h, expected %0d",
                                         mode_rd, sb.diamond_on));
        apb_write(REG_DIAMOND_MODE, {31'd0, mode});
        sb.diamond_on = mode;
    endtask

    // Offer one pixel, with random gaps between bursts, and hold until taken
    task automatic send_pixel(input logic [7:0] px);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        do @(posedge clk); while (!pix_if.ready);
        sb.note_pixel(px);
    endtask

    task automatic send_pixels(input int count, input row_style_t style);
        int         run_left;
        bit         run_solid;
        logic [7:0] px;
        run_left  = 0;
        run_solid = 1'($urandom_range(0, 1));
        for (int x = 0; x < count; x++)
        begin
            case (style)
                ROW_SOLID:  px = 8'($urandom_range(1, 255));
                ROW_CLEAR:  px = CLEAR_PIXEL;
                ROW_SPARSE: px = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255))
                                                             : CLEAR_PIXEL;
                ROW_NOISE:  px = 8'($urandom_range(0, 255));
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_solid = !run_solid;
                        run_left  = $urandom_range(1, 9);
                    end
                    run_left--;
                    px = run_solid ? 8'($urandom_range(1, 255)) : CLEAR_PIXEL;
                end
            endcase
            send_pixel(px);
        end
    endtask

    function automatic row_style_t pick_style();
        case ($urandom_range(0, 9))
            0:       return ROW_SOLID;
            1:       return ROW_CLEAR;
            2, 3:    return ROW_SPARSE;
            4:       return ROW_NOISE;
            default: return ROW_RUNS;
        endcase
    endfunction

    initial
    begin
        rst_n         <= 1'b0;
        pix_if.valid  <= 1'b0;
        pix_if.pixel  <= 8'd0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 2'd0;
        pwdata        <= 32'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rectangle tile: opening row, then a few random rows
        set_mode(MODE_RECT);
        foreach (OPENING_ROW[i])
            send_pixel(OPENING_ROW[i]);
        send_pixels(ROW_WIDTH_DEF - $size(OPENING_ROW), ROW_CLEAR);
        repeat (3) send_pixels(ROW_WIDTH_DEF, pick_style());

        // Switch to diamond in the middle of a row, then diamond rows
        send_pixels(13, ROW_SOLID);
        set_mode(MODE_DIAMOND);
        send_pixels(ROW_WIDTH_DEF - 13, pick_style());
        repeat (5) send_pixels(ROW_WIDTH_DEF, pick_style());

        // Back to rectangle in the middle of a row
        send_pixels(10, ROW_NOISE);
        set_mode(MODE_RECT);
        send_pixels(ROW_WIDTH_DEF - 10, ROW_NOISE);
        repeat (2) send_pixels(ROW_WIDTH_DEF, pick_style());

        // Diamond again: its last row closes the tile
        set_mode(MODE_DIAMOND);
        repeat (2) send_pixels(ROW_WIDTH_DEF, pick_style());

        // Drain and let the block settle
        pix_if.valid <= 1'b0;
        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
